@@ rtl/pvi_pkg.sv @@
// Package: unit codes, shared constants and the stage tail record.
`timescale 1ns / 1ps
package pvi_pkg;

  localparam int PORTION_BITS_DEF = 16;
  localparam int QBITS = 8;

  typedef enum logic [2:0] {
    UNIT_NULL    = 3'd0,
    UNIT_NORMAL  = 3'd1,
    UNIT_AUTO    = 3'd2,
    UNIT_NONE    = 3'd3,
    UNIT_COORD   = 3'd4,
    UNIT_PERCENT = 3'd5,
    UNIT_FLOAT   = 3'd6,
    UNIT_COLOR   = 3'd7
  } unit_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  unit;
    logic        color;
    logic        zero;
    logic [31:0] lin;
    logic [7:0]  alpha;
  } tail_t;

endpackage

@@ rtl/pvi_arith.sv @@
// Arithmetic front: products, linear result, blended alpha and divider operands.
`timescale 1ns / 1ps
module pvi_arith
  import pvi_pkg::*;
#(
  parameter int PORTION_BITS = PORTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  logic                          ok,
  input  logic [2:0]                    unit,
  input  logic [31:0]                   sv,
  input  logic [31:0]                   ev,
  input  logic [PORTION_BITS:0]         p,
  output tail_t                         tail,
  output logic [2:0][PORTION_BITS+17:0] num,
  output logic [PORTION_BITS+8:0]       den
);
  localparam int P  = PORTION_BITS;
  localparam int NW = P + 18;
  localparam logic [P:0] ONE = (P+1)'(1) << P;
  localparam logic [P+32:0] HALF = (P+33)'(1) << (P-1);
  localparam logic [P+8:0] AHALF = (P+9)'(1) << (P-1);

  // stage 1
  logic            ok1, color1, neg1;
  logic [2:0]      unit1;
  logic [31:0]     sv1, mag1;
  logic [P:0]      p1, q1;
  logic [7:0]      as1, ae1;
  logic [2:0][15:0] csas1, ceae1;
  logic [32:0]     d33, mag33;

  assign d33   = {ev[31], ev} - {sv[31], sv};
  assign mag33 = d33[32] ? (33'd0 - d33) : d33;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok1    <= ok;
      unit1  <= unit;
      color1 <= (unit == UNIT_COLOR);
      neg1   <= d33[32];
      sv1    <= sv;
      mag1   <= mag33[31:0];
      p1     <= p;
      q1     <= ONE - p;
      as1    <= sv[31:24];
      ae1    <= ev[31:24];
      for (int c = 0; c < 3; c++) begin
        csas1[c] <= sv[8*c +: 8] * sv[31:24];
        ceae1[c] <= ev[8*c +: 8] * ev[31:24];
      end
    end
  end

  // stage 2
  logic            ok2, color2, neg2;
  logic [2:0]      unit2;
  logic [31:0]     sv2;
  logic [P+32:0]   prod2;
  logic [P+8:0]    asq2, aep2;
  logic [2:0][P+16:0] ns2, ne2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok2    <= ok1;
      unit2  <= unit1;
      color2 <= color1;
      neg2   <= neg1;
      sv2    <= sv1;
      prod2  <= mag1 * p1;
      asq2   <= as1 * q1;
      aep2   <= ae1 * p1;
      for (int c = 0; c < 3; c++) begin
        ns2[c] <= csas1[c] * q1;
        ne2[c] <= ceae1[c] * p1;
      end
    end
  end

  // stage 3
  logic [P+32:0] rnd;
  logic [31:0]   step;
  logic [P+8:0]  asum;
  logic [P+8:0]  araw;

  assign rnd  = (prod2 + HALF) >> P;
  assign step = rnd[31:0];
  assign asum = asq2 + aep2;
  assign araw = (asum + AHALF) >> P;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tail.ok    <= ok2;
      tail.unit  <= unit2;
      tail.color <= color2;
      tail.zero  <= (asum == '0);
      tail.lin   <= neg2 ? (sv2 - step) : (sv2 + step);
      tail.alpha <= araw[7:0];
      den        <= {asum[P+7:0], 1'b0};
      for (int c = 0; c < 3; c++) begin
        num[c] <= {ns2[c] + ne2[c], 1'b0} + NW'(asum);
      end
    end
  end

endmodule

@@ rtl/pvi_div_step.sv @@
// One restoring divider stage: resolves one quotient bit for all three channels.
`timescale 1ns / 1ps
module pvi_div_step
  import pvi_pkg::*;
#(
  parameter int PORTION_BITS = PORTION_BITS_DEF,
  parameter int K = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  tail_t                         tail_in,
  input  logic [2:0][PORTION_BITS+17:0] rem_in,
  input  logic [2:0][QBITS-1:0]         quo_in,
  input  logic [PORTION_BITS+8:0]       den_in,
  output tail_t                         tail_out,
  output logic [2:0][PORTION_BITS+17:0] rem_out,
  output logic [2:0][QBITS-1:0]         quo_out,
  output logic [PORTION_BITS+8:0]       den_out
);
  localparam int NW = PORTION_BITS + 18;

  logic [NW-1:0] dsh;
  assign dsh = NW'(den_in) << K;

  always_ff @(posedge clk) begin
    if (en) begin
      tail_out <= tail_in;
      den_out  <= den_in;
      for (int c = 0; c < 3; c++) begin
        if (rem_in[c] >= dsh) begin
          rem_out[c]    <= rem_in[c] - dsh;
          quo_out[c]    <= quo_in[c] | (QBITS'(1) << K);
        end else begin
          rem_out[c]    <= rem_in[c];
          quo_out[c]    <= quo_in[c];
        end
      end
    end
  end

endmodule

@@ rtl/premultiplied_value_interpolator.sv @@
// Top level: tagged value interpolator, pipeline control and result stage.
//
//   channel | signals                                        | dir
//   in      | in_valid in_stall start_unit end_unit           | in
//           | start_value end_value portion                  |
//   out     | out_valid out_stall success result_unit        | out
//           | result_value                                   |
//
// One transfer per cycle while out_stall is low; stages in order: input stage, three
// arithmetic stages, eight divider stages, result stage. The divider chain
// sets the depth. Reset clears all stage valid bits. A stall only holds stages
// that are full and blocked, so bubbles close up while the output waits.
`timescale 1ns / 1ps
module premultiplied_value_interpolator
  import pvi_pkg::*;
#(
  parameter int PORTION_BITS = PORTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              start_unit,
  input  logic [2:0]              end_unit,
  input  logic [31:0]             start_value,
  input  logic [31:0]             end_value,
  input  logic [PORTION_BITS:0]   portion,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    success,
  output logic [2:0]              result_unit,
  output logic [31:0]             result_value
);
  localparam int P  = PORTION_BITS;
  localparam int NW = P + 18;
  localparam int NS = 5 + QBITS;
  localparam logic [P:0] ONE = (P+1)'(1) << P;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // input stage
  logic        ok0;
  logic [2:0]  unit0;
  logic [31:0] sv0, ev0;
  logic [P:0]  p0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ok0   <= (start_unit == end_unit) && (start_unit >= UNIT_COORD);
      unit0 <= start_unit;
      sv0   <= start_value;
      ev0   <= end_value;
      p0    <= (portion > ONE) ? ONE : portion;
    end
  end

  tail_t                 tail [QBITS+1];
  logic [2:0][NW-1:0]    rem  [QBITS+1];
  logic [2:0][QBITS-1:0] quo  [QBITS+1];
  logic [P+8:0]          den  [QBITS+1];

  pvi_arith #(.PORTION_BITS(P)) u_arith (
    .clk  (clk),
    .en   (rdy[3:1]),
    .ok   (ok0),
    .unit (unit0),
    .sv   (sv0),
    .ev   (ev0),
    .p    (p0),
    .tail (tail[0]),
    .num  (rem[0]),
    .den  (den[0])
  );
  assign quo[0] = '0;

  for (genvar g = 0; g < QBITS; g++) begin : g_div
    pvi_div_step #(.PORTION_BITS(P), .K(QBITS - 1 - g)) u_step (
      .clk      (clk),
      .en       (rdy[4+g]),
      .tail_in  (tail[g]),
      .rem_in   (rem[g]),
      .quo_in   (quo[g]),
      .den_in   (den[g]),
      .tail_out (tail[g+1]),
      .rem_out  (rem[g+1]),
      .quo_out  (quo[g+1]),
      .den_out  (den[g+1])
    );
  end

  // result stage
  tail_t                 tf;
  logic [2:0][QBITS-1:0] qf;
  assign tf = tail[QBITS];
  assign qf = quo[QBITS];

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      success     <= tf.ok;
      result_unit <= tf.ok ? tf.unit : UNIT_NULL;
      if (!tf.ok || (tf.color && tf.zero)) begin
        result_value <= '0;
      end else if (tf.color) begin
        result_value <= {tf.alpha, qf[2], qf[1], qf[0]};
      end else begin
        result_value <= tf.lin;
      end
    end
  end

  assign out_valid = vld[NS-1];

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !success |-> result_unit == UNIT_NULL && result_value == '0)
    else $error("failed result not cleared");
  a_ok_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && success |-> result_unit >= UNIT_COORD)
    else $error("success with non-interpolable unit");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted transfer lost at input stage");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !vld[NS-2] |=> !out_valid)
    else $error("result repeated");

endmodule
